// File: src/tmtw_pkg.sv
`timescale 1ns / 1ps

package tmtw_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int ACTION_W  = 2;
    localparam int CODE_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int CELL_W    = 16;
    localparam int COLOR_W   = 8;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;

    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0] CODE_RETURN  = 8'd13;
    localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
    localparam logic [CODE_W-1:0] CODE_BLANK   = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

    localparam int TAB_STEP    = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_CHAR,
        CMD_NEWLINE,
        CMD_RETURN,
        CMD_TAB,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [CODE_W-1:0]   code;
        logic [INDEX_W-1:0]  index;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_READ_WAIT
    } back_state_t;

endpackage

// File: src/tmtw_front.sv
`timescale 1ns / 1ps

module tmtw_front #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmtw_pkg::ROWS_DEFAULT
) (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tmtw_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [tmtw_pkg::ACTION_W-1:0]   s_tuser,
    output logic                            push_valid,
    input  logic                            push_ready,
    output tmtw_pkg::cmd_t                  push_cmd
);
    import tmtw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    logic [CODE_W-1:0]  code;
    logic [INDEX_W-1:0] index;
    logic               in_range;

    assign code     = s_tdata[CODE_W-1:0];
    assign index    = s_tdata[CODE_W+INDEX_W-1:CODE_W];
    assign in_range = 32'(index) < 32'(CELLS);

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;

    always_comb
    begin
        push_cmd.code  = code;
        push_cmd.index = index;
        case (s_tuser)
            ACT_PUT:
            begin
                case (code)
                    CODE_NEWLINE: push_cmd.kind = CMD_NEWLINE;
                    CODE_RETURN:  push_cmd.kind = CMD_RETURN;
                    CODE_TAB:     push_cmd.kind = CMD_TAB;
                    default:      push_cmd.kind = CMD_CHAR;
                endcase
            end
            ACT_CLEAR: push_cmd.kind = CMD_CLEAR;
            // out-of-range reads report a zero cell, same as a no-op
            ACT_READ:  push_cmd.kind = in_range ? CMD_READ : CMD_NOP;
            default:   push_cmd.kind = CMD_NOP;
        endcase
    end

endmodule

// File: src/tmtw_queue.sv
`timescale 1ns / 1ps

module tmtw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  tmtw_pkg::cmd_t  push_cmd,
    output logic            pop_valid,
    input  logic            pop_ready,
    output tmtw_pkg::cmd_t  pop_cmd
);
    import tmtw_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != FULL_CNT;
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: src/tmtw_back.sv
`timescale 1ns / 1ps

module tmtw_back #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmtw_pkg::ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  tmtw_pkg::cmd_t                  pop_cmd,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tmtw_pkg::COLOR_W-1:0]    cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tmtw_pkg::M_DATA_W-1:0]   m_tdata
);
    import tmtw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RWX   = RW + ROW_OUT_W;
    localparam int CWX   = CW + COL_OUT_W;
    localparam int PAD_W = M_DATA_W - (ROW_OUT_W + COL_OUT_W + 1 + CELL_W);

    localparam logic [AW-1:0]   LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0]   ROW_SPAN   = AW'(COLUMNS - 1);
    localparam logic [AW:0]     CELLS_X    = (AW+1)'(CELLS);
    localparam logic [AW:0]     COLS_X     = (AW+1)'(COLUMNS);
    localparam logic [RW-1:0]   LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CW-1:0]   LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [CW:0]     COLS_C     = (CW+1)'(COLUMNS);
    localparam logic [CW:0]     TAB_ADD    = (CW+1)'(TAB_STEP);
    localparam logic [CW:0]     TAB_MASK   = ~((CW+1)'(TAB_STEP - 1));

    logic [CELL_W-1:0]  mem [CELLS];
    logic [CELL_W-1:0]  rd_data_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [RW-1:0]      row_reg;
    logic [RW-1:0]      row_next;
    logic [CW-1:0]      col_reg;
    logic [CW-1:0]      col_next;
    logic [AW-1:0]      top_reg;
    logic [AW-1:0]      top_next;
    cmd_t               cmd_reg;
    cmd_t               cmd_next;
    logic [AW-1:0]      lin_reg;
    logic [AW-1:0]      lin_next;
    logic [AW-1:0]      fill_addr_reg;
    logic [AW-1:0]      fill_addr_next;
    logic [AW-1:0]      fill_last_reg;
    logic [AW-1:0]      fill_last_next;
    logic [CELL_W-1:0]  fill_cell_reg;
    logic [CELL_W-1:0]  fill_cell_next;
    logic               fill_emit_reg;
    logic               fill_emit_next;
    logic               scrolled_reg;
    logic               scrolled_next;
    logic [COLOR_W-1:0] color_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ROW_OUT_W-1:0] out_row_reg;
    logic [ROW_OUT_W-1:0] out_row_next;
    logic [COL_OUT_W-1:0] out_col_reg;
    logic [COL_OUT_W-1:0] out_col_next;
    logic                 out_scrolled_reg;
    logic                 out_scrolled_next;
    logic [CELL_W-1:0]    out_cell_reg;
    logic [CELL_W-1:0]    out_cell_next;

    logic               take;
    logic [CW:0]        tab_col;
    logic               tab_wrap;
    logic               char_wrap;
    logic               need_row;
    logic               do_scroll;
    logic               fill_done;
    logic               emit;
    logic [AW:0]        phys_sum;
    logic [AW-1:0]      phys;
    logic [AW:0]        top_plus;
    logic [RWX-1:0]     row_wide;
    logic [CWX-1:0]     col_wide;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;

    assign cfg_ready = 1'b1;
    assign pop_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign take      = pop_valid && pop_ready;

    // logical cell to physical cell, rows rotate on scroll
    assign phys_sum = (AW+1)'(lin_reg) + (AW+1)'(top_reg);
    assign phys     = (phys_sum >= CELLS_X) ? AW'(phys_sum - CELLS_X) : AW'(phys_sum);
    assign top_plus = (AW+1)'(top_reg) + COLS_X;

    assign tab_col   = ((CW+1)'(col_reg) + TAB_ADD) & TAB_MASK;
    assign tab_wrap  = tab_col >= COLS_C;
    assign char_wrap = col_reg == LAST_COL;
    assign fill_done = (state_reg == ST_FILL) && (fill_addr_reg == fill_last_reg);

    always_comb
    begin
        need_row = 1'b0;
        emit     = 1'b0;
        if (take)
        begin
            case (pop_cmd.kind)
                CMD_NEWLINE: need_row = 1'b1;
                CMD_TAB:     need_row = tab_wrap;
                default:     need_row = 1'b0;
            endcase
        end
        else if (state_reg == ST_WRITE)
        begin
            need_row = char_wrap;
        end
        do_scroll = need_row && (row_reg == LAST_ROW);
        if (fill_done && fill_emit_reg)
        begin
            emit = 1'b1;
        end
        else if (take)
        begin
            case (pop_cmd.kind)
                CMD_NEWLINE, CMD_RETURN, CMD_TAB, CMD_NOP: emit = !do_scroll;
                default:                                   emit = 1'b0;
            endcase
        end
        else if (state_reg == ST_WRITE)
        begin
            emit = !do_scroll;
        end
        else if (state_reg == ST_READ_WAIT)
        begin
            emit = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    case (pop_cmd.kind)
                        CMD_CHAR:    state_next = ST_WRITE;
                        CMD_CLEAR:   state_next = ST_FILL;
                        CMD_READ:    state_next = ST_READ;
                        CMD_NEWLINE,
                        CMD_TAB:     state_next = do_scroll ? ST_FILL : ST_IDLE;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:     state_next = do_scroll ? ST_FILL : ST_IDLE;
            ST_READ:      state_next = ST_READ_WAIT;
            ST_READ_WAIT: state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        row_next          = row_reg;
        col_next          = col_reg;
        top_next          = top_reg;
        cmd_next          = cmd_reg;
        lin_next          = lin_reg;
        fill_addr_next    = fill_addr_reg;
        fill_last_next    = fill_last_reg;
        fill_cell_next    = fill_cell_reg;
        fill_emit_next    = fill_emit_reg;
        scrolled_next     = scrolled_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_scrolled_next = out_scrolled_reg;
        out_cell_next     = out_cell_reg;

        if (take)
        begin
            cmd_next = pop_cmd;
            case (pop_cmd.kind)
                CMD_CHAR:    lin_next = AW'(row_reg * COLUMNS) + AW'(col_reg);
                CMD_NEWLINE: col_next = '0;
                CMD_RETURN:  col_next = '0;
                CMD_TAB:     col_next = tab_wrap ? '0 : CW'(tab_col);
                CMD_CLEAR:
                begin
                    row_next       = '0;
                    col_next       = '0;
                    top_next       = '0;
                    fill_addr_next = '0;
                    fill_last_next = LAST_CELL;
                    fill_cell_next = {color_reg, CODE_BLANK};
                    fill_emit_next = 1'b1;
                    scrolled_next  = 1'b0;
                end
                CMD_READ:    lin_next = AW'(pop_cmd.index);
                default:     lin_next = lin_reg;
            endcase
        end

        if (state_reg == ST_WRITE)
        begin
            col_next = char_wrap ? '0 : col_reg + 1'b1;
        end

        if (state_reg == ST_FILL && !fill_done)
        begin
            fill_addr_next = fill_addr_reg + 1'b1;
        end

        if (need_row)
        begin
            if (do_scroll)
            begin
                // old top row becomes the blank bottom row
                fill_addr_next = top_reg;
                fill_last_next = top_reg + ROW_SPAN;
                fill_cell_next = {color_reg, CODE_BLANK};
                fill_emit_next = 1'b1;
                scrolled_next  = 1'b1;
                top_next       = (top_plus >= CELLS_X) ? '0 : AW'(top_plus);
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end

        row_wide = RWX'(row_next);
        col_wide = CWX'(col_next);
        if (emit)
        begin
            out_valid_next    = 1'b1;
            out_row_next      = row_wide[ROW_OUT_W-1:0];
            out_col_next      = col_wide[COL_OUT_W-1:0];
            out_scrolled_next = (state_reg == ST_FILL) ? scrolled_reg : 1'b0;
            out_cell_next     = (state_reg == ST_READ_WAIT) ? rd_data_reg : '0;
        end
    end

    assign mem_we    = (state_reg == ST_FILL) || (state_reg == ST_WRITE);
    assign mem_waddr = (state_reg == ST_FILL) ? fill_addr_reg : phys;
    assign mem_wdata = (state_reg == ST_FILL) ? fill_cell_reg : {color_reg, cmd_reg.code};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[phys];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            row_reg       <= '0;
            col_reg       <= '0;
            top_reg       <= '0;
            fill_addr_reg <= '0;
            fill_last_reg <= LAST_CELL;
            fill_cell_reg <= {RESET_COLOR, CODE_BLANK};
            fill_emit_reg <= 1'b0;
            scrolled_reg  <= 1'b0;
            color_reg     <= RESET_COLOR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            top_reg       <= top_next;
            fill_addr_reg <= fill_addr_next;
            fill_last_reg <= fill_last_next;
            fill_cell_reg <= fill_cell_next;
            fill_emit_reg <= fill_emit_next;
            scrolled_reg  <= scrolled_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        lin_reg          <= lin_next;
        out_row_reg      <= out_row_next;
        out_col_reg      <= out_col_next;
        out_scrolled_reg <= out_scrolled_next;
        out_cell_reg     <= out_cell_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_cell_reg, out_scrolled_reg, out_col_reg, out_row_reg};

endmodule

// File: src/text_mode_terminal_writer.sv
`timescale 1ns / 1ps

// Character-cell terminal with a ROWS x COLUMNS screen of 16-bit cells (character in
// the low byte, colour in the high byte) and a cursor. Items come in on the s_ side
// and are classified into a two-entry queue; the screen engine behind it owns the
// screen memory and gives one result per item on the m_ side, held in an
// output register. The engine takes the next item only when it is idle and its output
// register is free or being read; a read with an index past the screen is handled
// like an unused action. A scroll blanks the new bottom row one cell a cycle (rows
// rotate, nothing is copied) and a clear blanks every cell, both through the one write
// port of the screen memory. After reset the engine blanks all ROWS*COLUMNS cells
// before it carries out the first item; items are still queued during that sweep.
// The colour register is written through cfg_valid/cfg_data and should only change
// while idle.
module text_mode_terminal_writer #(
    parameter int COLUMNS = tmtw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmtw_pkg::ROWS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_code [7:0], cell_index [18:8], zero [23:19]
    input  logic [tmtw_pkg::S_DATA_W-1:0]   s_tdata,
    // action [1:0]
    input  logic [tmtw_pkg::ACTION_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cursor_row [4:0], cursor_col [11:5], scrolled [12], read_cell [28:13], zero [31:29]
    output logic [tmtw_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tmtw_pkg::COLOR_W-1:0]    cfg_data
);
    import tmtw_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    tmtw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    tmtw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    tmtw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
